@@ rtl/core/bmum_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmum_pkg
// Shared types, codes and defaults of the binary mask upsample/morphology block.
// ----------------------------------------------------------------------------
package bmum_pkg;

   localparam int DEF_MAX_ROWS       = 128;
   localparam int DEF_MAX_COLUMNS    = 128;
   localparam int DEF_FEATURE_STRIDE = 52;
   localparam int DEF_FEATURE_DEPTH  = 4096;
   localparam int DEF_PACKED_DEPTH   = 2048;

   // coordinate counters cover row_count + 2 and column_count + 2
   localparam int CO_W = 9;
   // width of the settings check arithmetic
   localparam int CK_W = 17;
   // one dilation followed by four erosions
   localparam int MORPH_PASSES = 5;

   localparam logic [7:0]  RST_ROW_COUNT       = 8'd88;
   localparam logic [7:0]  RST_COLUMN_COUNT    = 8'd108;
   localparam logic [12:0] RST_FEATURE_COUNT   = 13'd2288;
   localparam logic [11:0] RST_PACKED_CAPACITY = 12'd1144;

   typedef enum logic [1:0] {
      KIND_LOAD  = 2'd0,
      KIND_BUILD = 2'd1,
      KIND_READ  = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REG_ROW_COUNT       = 2'd0,
      REG_COLUMN_COUNT    = 2'd1,
      REG_FEATURE_COUNT   = 2'd2,
      REG_PACKED_CAPACITY = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_RUN,
      ST_ZERO
   } state_type;

endpackage

@@ rtl/core/bmum_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmum_req_if
// Request channel: valid/ready handshake with the request item fields.
// ----------------------------------------------------------------------------
interface bmum_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [11:0] feature_address;
   logic [7:0]  feature_byte;
   logic [10:0] read_address;

   modport source (output valid, kind, feature_address, feature_byte, read_address,
                   input ready);
   modport sink   (input valid, kind, feature_address, feature_byte, read_address,
                   output ready);
endinterface

@@ rtl/core/bmum_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmum_rsp_if
// Response channel: valid/ready handshake with status and packed byte.
// ----------------------------------------------------------------------------
interface bmum_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic [7:0] packed_byte;

   modport source (output valid, status, packed_byte, input ready);
   modport sink   (input valid, status, packed_byte, output ready);
endinterface

@@ rtl/core/bmum_source.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmum_source
// Feature store and 2x upsampling pixel source, one raster slot per cycle.
// ----------------------------------------------------------------------------
module bmum_source #(
   parameter int MAX_ROWS       = bmum_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLUMNS    = bmum_pkg::DEF_MAX_COLUMNS,
   parameter int FEATURE_STRIDE = bmum_pkg::DEF_FEATURE_STRIDE,
   parameter int FEATURE_DEPTH  = bmum_pkg::DEF_FEATURE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  rows,
   input  logic [7:0]  cols,
   input  logic [12:0] feature_count,
   input  logic        start,
   input  logic        wr_en,
   input  logic [11:0] wr_addr,
   input  logic        wr_bit,
   output logic        out_valid,
   output logic        out_bit
);
   import bmum_pkg::*;

   localparam int FA_W  = $clog2(FEATURE_DEPTH);
   localparam int FI_W  = $clog2((MAX_ROWS / 2 + 1) * FEATURE_STRIDE + MAX_COLUMNS) + 1;
   localparam int CMP_W = (FI_W > CK_W) ? FI_W : CK_W;

   logic feat_mem [FEATURE_DEPTH];

   logic            run_ff, run_in;
   logic [CO_W-1:0] y_ff, y_in, x_ff, x_in;
   logic [FI_W-1:0] base_ff, base_in, fi;
   logic [CO_W-1:0] rows_w, cols_w;
   logic            valid_ff, ok_ff, rd_ff;
   logic            ok_now;

   assign rows_w = CO_W'(rows);
   assign cols_w = CO_W'(cols);
   assign fi     = base_ff + FI_W'(x_ff >> 1);

   always_comb begin
      run_in  = run_ff;
      y_in    = y_ff;
      x_in    = x_ff;
      base_in = base_ff;
      if (start) begin
         run_in  = 1'b1;
         y_in    = '0;
         x_in    = '0;
         base_in = '0;
      end else if (run_ff) begin
         if (x_ff == cols_w + CO_W'(1)) begin
            x_in = '0;
            y_in = y_ff + CO_W'(1);
            if (y_ff[0]) begin
               base_in = base_ff + FI_W'(FEATURE_STRIDE);
            end
            if (y_ff == rows_w - CO_W'(1)) begin
               run_in = 1'b0;
            end
         end else begin
            x_in = x_ff + CO_W'(1);
         end
      end
      ok_now = run_ff && (x_ff >= CO_W'(2)) && (x_ff + CO_W'(2) < cols_w) &&
               (CMP_W'(fi) < CMP_W'(feature_count)) &&
               (CMP_W'(fi) < CMP_W'(FEATURE_DEPTH));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         run_ff   <= run_in;
         valid_ff <= run_ff && (x_ff < cols_w);
      end
      y_ff    <= y_in;
      x_ff    <= x_in;
      base_ff <= base_in;
      ok_ff   <= ok_now;
      rd_ff   <= feat_mem[FA_W'(fi)];
      if (wr_en && (CMP_W'(wr_addr) < CMP_W'(FEATURE_DEPTH))) begin
         feat_mem[FA_W'(wr_addr)] <= wr_bit;
      end
   end

   assign out_valid = valid_ff;
   assign out_bit   = ok_ff & rd_ff;

endmodule

@@ rtl/core/bmum_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmum_cell
// One radius-2 plus-shaped dilation or erosion pass over a raster stream,
// with a four-row column buffer and a five-column horizontal window.
// ----------------------------------------------------------------------------
module bmum_cell #(
   parameter int MAX_COLUMNS = bmum_pkg::DEF_MAX_COLUMNS,
   parameter bit DILATE      = 1'b0
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] rows,
   input  logic [7:0] cols,
   input  logic       in_valid,
   input  logic       in_bit,
   output logic       out_valid,
   output logic       out_bit
);
   import bmum_pkg::*;

   localparam int CW = $clog2(MAX_COLUMNS);

   logic [3:0] line_mem [MAX_COLUMNS];

   logic            run_ff, run_in;
   logic [CO_W-1:0] y_ff, y_in, x_ff, x_in, sy, sx;
   logic [CO_W-1:0] rows_w, cols_w;
   logic            act;

   logic            s1_act_ff;
   logic [CO_W-1:0] s1_y_ff, s1_x_ff;
   logic            s1_bit_ff;
   logic [3:0]      word_ff;
   logic [3:0]      h_sr_ff;
   logic [1:0]      v_sr_ff;
   logic            out_valid_ff, out_bit_ff;

   logic            bdr;
   logic [4:0]      vtap;
   logic [3:0]      htap;
   logic            v_now, res, emit;

   assign rows_w = CO_W'(rows);
   assign cols_w = CO_W'(cols);
   assign bdr    = !DILATE;

   always_comb begin
      act    = run_ff | in_valid;
      sy     = run_ff ? y_ff : '0;
      sx     = run_ff ? x_ff : '0;
      run_in = run_ff;
      y_in   = y_ff;
      x_in   = x_ff;
      if (act) begin
         if (sx == cols_w + CO_W'(1)) begin
            x_in   = '0;
            y_in   = sy + CO_W'(1);
            run_in = (sy != rows_w + CO_W'(1));
         end else begin
            x_in   = sx + CO_W'(1);
            y_in   = sy;
            run_in = 1'b1;
         end
      end
   end

   always_comb begin
      vtap[0] = (s1_y_ff < rows_w) ? s1_bit_ff : bdr;
      for (int k = 1; k < 5; k++) begin
         vtap[k] = ((s1_y_ff >= CO_W'(k)) && (s1_y_ff - CO_W'(k) < rows_w)) ?
                   word_ff[k-1] : bdr;
      end
      v_now   = DILATE ? (|vtap) : (&vtap);
      htap[0] = (s1_x_ff >= CO_W'(4)) ? h_sr_ff[3] : bdr;
      htap[1] = (s1_x_ff >= CO_W'(3)) ? h_sr_ff[2] : bdr;
      htap[2] = (s1_x_ff <= cols_w) ? h_sr_ff[0] : bdr;
      htap[3] = (s1_x_ff < cols_w) ? word_ff[1] : bdr;
      res     = DILATE ? ((|htap) | v_sr_ff[1]) : ((&htap) & v_sr_ff[1]);
      emit    = s1_act_ff && (s1_y_ff >= CO_W'(2)) && (s1_x_ff >= CO_W'(2));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff       <= 1'b0;
         s1_act_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         run_ff       <= run_in;
         s1_act_ff    <= act;
         out_valid_ff <= emit;
      end
      y_ff       <= y_in;
      x_ff       <= x_in;
      s1_y_ff    <= sy;
      s1_x_ff    <= sx;
      s1_bit_ff  <= ((sy < rows_w) && (sx < cols_w)) ? in_bit : 1'b0;
      word_ff    <= line_mem[sx[CW-1:0]];
      out_bit_ff <= res;
      if (s1_act_ff) begin
         h_sr_ff <= {h_sr_ff[2:0], word_ff[1]};
         v_sr_ff <= {v_sr_ff[0], v_now};
      end
      if (s1_act_ff && (s1_x_ff < cols_w)) begin
         line_mem[s1_x_ff[CW-1:0]] <= {word_ff[2:0], s1_bit_ff};
      end
   end

   assign out_valid = out_valid_ff;
   assign out_bit   = out_bit_ff;

endmodule

@@ rtl/core/bmum_packer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmum_packer
// Packs the inner columns of the final mask LSB-first into bytes.
// ----------------------------------------------------------------------------
module bmum_packer #(
   parameter int PACKED_DEPTH = bmum_pkg::DEF_PACKED_DEPTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [7:0]                            rows,
   input  logic [7:0]                            cols,
   input  logic                                  start,
   input  logic                                  in_valid,
   input  logic                                  in_bit,
   output logic                                  wr_en,
   output logic [$clog2(PACKED_DEPTH + 1)-1:0]   wr_addr,
   output logic [7:0]                            wr_data,
   output logic [$clog2(PACKED_DEPTH + 1)-1:0]   end_addr,
   output logic                                  done
);
   import bmum_pkg::*;

   localparam int PAW1 = $clog2(PACKED_DEPTH + 1);

   logic [CO_W-1:0] y_ff, y_in, x_ff, x_in;
   logic [2:0]      cnt_ff, cnt_in;
   logic [7:0]      acc_ff, acc_in, acc_set;
   logic [PAW1-1:0] addr_ff, addr_in;
   logic            we_ff, we_in, done_ff, done_in;
   logic [PAW1-1:0] wa_ff, wa_in;
   logic [7:0]      wd_ff, wd_in;
   logic            inner, last;
   logic [CO_W-1:0] rows_w, cols_w;

   assign rows_w = CO_W'(rows);
   assign cols_w = CO_W'(cols);

   always_comb begin
      inner   = (x_ff >= CO_W'(2)) && (x_ff + CO_W'(2) < cols_w);
      last    = (y_ff == rows_w - CO_W'(1)) && (x_ff == cols_w - CO_W'(1));
      acc_set = acc_ff | (8'(in_bit) << cnt_ff);
      y_in    = y_ff;
      x_in    = x_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      addr_in = addr_ff;
      we_in   = 1'b0;
      wa_in   = addr_ff;
      wd_in   = acc_set;
      done_in = 1'b0;
      if (start) begin
         y_in    = '0;
         x_in    = '0;
         cnt_in  = '0;
         acc_in  = '0;
         addr_in = '0;
      end else if (in_valid) begin
         if (x_ff == cols_w - CO_W'(1)) begin
            x_in = '0;
            y_in = y_ff + CO_W'(1);
         end else begin
            x_in = x_ff + CO_W'(1);
         end
         if (inner) begin
            if (cnt_ff == 3'd7) begin
               we_in   = 1'b1;
               addr_in = addr_ff + PAW1'(1);
               acc_in  = '0;
               cnt_in  = '0;
            end else begin
               acc_in = acc_set;
               cnt_in = cnt_ff + 3'd1;
            end
         end else if (last && (cnt_ff != 3'd0)) begin
            we_in   = 1'b1;
            wd_in   = acc_ff;
            addr_in = addr_ff + PAW1'(1);
         end
         done_in = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         we_ff   <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         we_ff   <= we_in;
         done_ff <= done_in;
      end
      y_ff    <= y_in;
      x_ff    <= x_in;
      cnt_ff  <= cnt_in;
      acc_ff  <= acc_in;
      addr_ff <= addr_in;
      wa_ff   <= wa_in;
      wd_ff   <= wd_in;
   end

   assign wr_en    = we_ff;
   assign wr_addr  = wa_ff;
   assign wr_data  = wd_ff;
   assign end_addr = addr_ff;
   assign done     = done_ff;

endmodule

@@ rtl/core/binary_mask_upsample_morphology.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_mask_upsample_morphology
// Upsamples a binary feature map 2x, runs one plus-shaped radius-2 dilation
// and four erosions, packs the inner columns into a byte store.
//
// Usage: request items arrive on req_ch (valid/ready), one response item per
// request leaves on rsp_ch. Settings are to be written over the APB port
// while idle; the block does not enforce this. Load items write the feature
// store and answer in the next cycle. Read items pass the READ state and
// return a packed byte from the response register. A build item checks the
// settings in the CHECK state (status 1 on rejection); otherwise it streams
// the image from the one-pixel-per-cycle raster source through a chain of
// five morphology cells, then zeroes the bytes after the packed result up
// to the packed capacity, at most PACKED_DEPTH. One item is in flight at a
// time; ready is held low until it completes. After reset the packed store
// is cleared, during which no item is taken. A stalled receiver holds the
// response register and the next request waits for it to drain.
// ----------------------------------------------------------------------------
module binary_mask_upsample_morphology #(
   parameter int MAX_ROWS       = bmum_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLUMNS    = bmum_pkg::DEF_MAX_COLUMNS,
   parameter int FEATURE_STRIDE = bmum_pkg::DEF_FEATURE_STRIDE,
   parameter int FEATURE_DEPTH  = bmum_pkg::DEF_FEATURE_DEPTH,
   parameter int PACKED_DEPTH   = bmum_pkg::DEF_PACKED_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   bmum_req_if.sink    req_ch,
   bmum_rsp_if.source  rsp_ch,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import bmum_pkg::*;

   localparam int PA_W = $clog2(PACKED_DEPTH);
   localparam int PAW1 = $clog2(PACKED_DEPTH + 1);

   logic [7:0]  rows_ff, cols_ff;
   logic [12:0] fcount_ff;
   logic [11:0] cap_ff;

   state_type       state_ff, state_in;
   logic [PAW1-1:0] sweep_ff, sweep_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_status_ff, rsp_status_in;
   logic [7:0]      rsp_byte_ff, rsp_byte_in;
   logic            ra_ok_ff;
   logic [7:0]      rd_ff;

   logic [7:0]      pk_mem [PACKED_DEPTH];
   logic            mem_we;
   logic [PAW1-1:0] mem_wa;
   logic [7:0]      mem_wd;

   logic            accept, start;
   logic            feat_we;
   logic            reject;
   logic [7:0]      rm1, cm3, inner_cols;
   logic [CK_W-1:0] max_index, need_bytes, zero_lim;

   logic [MORPH_PASSES:0] c_valid, c_bit;

   logic            pk_we, pk_done;
   logic [PAW1-1:0] pk_wa, pk_end;
   logic [7:0]      pk_wd;

   // configuration port
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff   <= RST_ROW_COUNT;
         cols_ff   <= RST_COLUMN_COUNT;
         fcount_ff <= RST_FEATURE_COUNT;
         cap_ff    <= RST_PACKED_CAPACITY;
      end else if (psel && penable && pwrite) begin
         unique case (reg_index_type'(paddr[3:2]))
            REG_ROW_COUNT:       rows_ff   <= pwdata[7:0];
            REG_COLUMN_COUNT:    cols_ff   <= pwdata[7:0];
            REG_FEATURE_COUNT:   fcount_ff <= pwdata[12:0];
            REG_PACKED_CAPACITY: cap_ff    <= pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_index_type'(paddr[3:2]))
         REG_ROW_COUNT:       prdata = 32'(rows_ff);
         REG_COLUMN_COUNT:    prdata = 32'(cols_ff);
         REG_FEATURE_COUNT:   prdata = 32'(fcount_ff);
         REG_PACKED_CAPACITY: prdata = 32'(cap_ff);
         default:             prdata = '0;
      endcase
   end

   // settings check
   always_comb begin
      rm1        = rows_ff - 8'd1;
      cm3        = cols_ff - 8'd3;
      inner_cols = cols_ff - 8'd4;
      max_index  = CK_W'(rm1[7:1]) * CK_W'(FEATURE_STRIDE) + CK_W'(cm3[7:1]);
      need_bytes = (CK_W'(rows_ff) * CK_W'(inner_cols) + CK_W'(7)) >> 3;
      reject     = (rows_ff < 8'd2) || (cols_ff <= 8'd4) || (fcount_ff == '0) ||
                   (CK_W'(rows_ff) > CK_W'(MAX_ROWS)) ||
                   (CK_W'(cols_ff) > CK_W'(MAX_COLUMNS)) ||
                   (CK_W'(fcount_ff) < max_index) ||
                   (CK_W'(cap_ff) < need_bytes) ||
                   (need_bytes > CK_W'(PACKED_DEPTH));
      zero_lim   = (CK_W'(cap_ff) < CK_W'(PACKED_DEPTH)) ? CK_W'(cap_ff) :
                   CK_W'(PACKED_DEPTH);
   end

   // control
   assign req_ch.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      mem_we        = 1'b0;
      mem_wa        = sweep_ff;
      mem_wd        = '0;
      start         = 1'b0;
      feat_we       = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            if (sweep_ff == PAW1'(PACKED_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               sweep_in = sweep_ff + PAW1'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               unique case (kind_type'(req_ch.kind))
                  KIND_LOAD: begin
                     feat_we       = 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = 1'b0;
                     rsp_byte_in   = '0;
                  end
                  KIND_BUILD: state_in = ST_CHECK;
                  KIND_READ:  state_in = ST_READ;
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = 1'b0;
                     rsp_byte_in   = '0;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = 1'b0;
            rsp_byte_in   = ra_ok_ff ? rd_ff : '0;
            state_in      = ST_IDLE;
         end
         ST_CHECK: begin
            if (reject) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = 1'b1;
               rsp_byte_in   = '0;
               state_in      = ST_IDLE;
            end else begin
               start    = 1'b1;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            mem_we = pk_we;
            mem_wa = pk_wa;
            mem_wd = pk_wd;
            if (pk_done) begin
               sweep_in = pk_end;
               state_in = ST_ZERO;
            end
         end
         ST_ZERO: begin
            if (CK_W'(sweep_ff) < zero_lim) begin
               mem_we   = 1'b1;
               sweep_in = sweep_ff + PAW1'(1);
            end else begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = 1'b0;
               rsp_byte_in   = '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
   end

   // packed store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pk_mem[PA_W'(mem_wa)] <= mem_wd;
      end
      rd_ff    <= pk_mem[PA_W'(req_ch.read_address)];
      ra_ok_ff <= CK_W'(req_ch.read_address) < CK_W'(PACKED_DEPTH);
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.packed_byte = rsp_byte_ff;

   // datapath
   bmum_source #(
      .MAX_ROWS       (MAX_ROWS),
      .MAX_COLUMNS    (MAX_COLUMNS),
      .FEATURE_STRIDE (FEATURE_STRIDE),
      .FEATURE_DEPTH  (FEATURE_DEPTH)
   ) u_source (
      .clock         (clock),
      .reset         (reset),
      .rows          (rows_ff),
      .cols          (cols_ff),
      .feature_count (fcount_ff),
      .start         (start),
      .wr_en         (feat_we),
      .wr_addr       (req_ch.feature_address),
      .wr_bit        (|req_ch.feature_byte),
      .out_valid     (c_valid[0]),
      .out_bit       (c_bit[0])
   );

   for (genvar g = 0; g < MORPH_PASSES; g++) begin : g_cell
      bmum_cell #(
         .MAX_COLUMNS (MAX_COLUMNS),
         .DILATE      (g == 0)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .rows      (rows_ff),
         .cols      (cols_ff),
         .in_valid  (c_valid[g]),
         .in_bit    (c_bit[g]),
         .out_valid (c_valid[g+1]),
         .out_bit   (c_bit[g+1])
      );
   end

   bmum_packer #(
      .PACKED_DEPTH (PACKED_DEPTH)
   ) u_packer (
      .clock    (clock),
      .reset    (reset),
      .rows     (rows_ff),
      .cols     (cols_ff),
      .start    (start),
      .in_valid (c_valid[MORPH_PASSES]),
      .in_bit   (c_bit[MORPH_PASSES]),
      .wr_en    (pk_we),
      .wr_addr  (pk_wa),
      .wr_data  (pk_wd),
      .end_addr (pk_end),
      .done     (pk_done)
   );

endmodule

@@ dv/binary_mask_upsample_morphology_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_mask_upsample_morphology_test
// Self-checking bench for the binary mask upsample/morphology block. Loads
// feature bytes, builds masks under many image settings (accepted and
// rejected), reads back packed bytes and compares every response item with
// an in-bench model of the upsample, dilate/erode and pack steps. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module binary_mask_upsample_morphology_test;
   import bmum_pkg::*;

   localparam int STRIDE      = 52;
   localparam int FEAT_DEPTH  = 4096;
   localparam int PACK_DEPTH  = 2048;
   localparam int PLANE_CELLS = 128 * 128;
   localparam int WATCH_LIMIT = 200000;

   typedef struct {
      logic       status;
      logic [7:0] packed_byte;
   } answer_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   bmum_req_if req_ch();
   bmum_rsp_if rsp_ch();

   binary_mask_upsample_morphology i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // model state
   logic [7:0]  rows_set;
   logic [7:0]  cols_set;
   logic [12:0] feat_count_set;
   logic [11:0] capacity_set;
   bit          feat_active [FEAT_DEPTH];
   bit          feat_written [FEAT_DEPTH];
   bit          plane_a [PLANE_CELLS];
   bit          plane_b [PLANE_CELLS];
   logic [7:0]  packed_mask [PACK_DEPTH];

   answer_type  pending_answers[$];
   int          mismatches;
   int          watch_count;
   int          loads_sent, builds_ok, builds_rejected, reads_sent;
   bit          quiet;
   int          rsp_stall_left;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int gap_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (quiet || pick < 60) return 0;
      if (pick < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // plus-shaped radius-2 pass from plane_a into plane_a
   task automatic morph_pass(input bit grow);
      int dy[9] = '{0, 0, 0, -1, 1, 0, 0, -2, 2};
      int dx[9] = '{0, -1, 1, 0, 0, -2, 2, 0, 0};
      int r, c, ny, nx;
      bit v, any_on, all_on;
      r = int'(rows_set);
      c = int'(cols_set);
      for (int y = 0; y < r; y++) begin
         for (int x = 0; x < c; x++) begin
            any_on = 1'b0;
            all_on = 1'b1;
            for (int k = 0; k < 9; k++) begin
               ny = y + dy[k];
               nx = x + dx[k];
               if (ny < 0 || nx < 0 || ny >= r || nx >= c) v = !grow;
               else v = plane_a[ny * c + nx];
               any_on |= v;
               all_on &= v;
            end
            plane_b[y * c + x] = grow ? any_on : all_on;
         end
      end
      for (int i = 0; i < r * c; i++) plane_a[i] = plane_b[i];
   endtask

   task automatic predict_mask_build(output logic rejected);
      int r, c, inner, need, top_index, zero_len, fi, bit_pos;
      r = int'(rows_set);
      c = int'(cols_set);
      rejected = 1'b1;
      if (r < 2 || c <= 4 || feat_count_set == 0 || r > 128 || c > 128) return;
      inner     = c - 4;
      top_index = ((r - 1) / 2) * STRIDE + (c - 3) / 2;
      need      = (r * inner + 7) / 8;
      if (feat_count_set < top_index || capacity_set < need || need > PACK_DEPTH) return;
      rejected = 1'b0;
      for (int i = 0; i < r * c; i++) plane_a[i] = 1'b0;
      for (int y = 0; y < r; y++) begin
         for (int x = 2; x + 2 < c; x++) begin
            fi = (y / 2) * STRIDE + x / 2;
            plane_a[y * c + x] = fi < feat_count_set && fi < FEAT_DEPTH && feat_active[fi];
         end
      end
      morph_pass(1'b1);
      repeat (4) morph_pass(1'b0);
      zero_len = capacity_set < PACK_DEPTH ? int'(capacity_set) : PACK_DEPTH;
      for (int i = 0; i < zero_len; i++) packed_mask[i] = 8'h00;
      for (int y = 0; y < r; y++) begin
         for (int x = 2; x + 2 < c; x++) begin
            bit_pos = y * inner + x - 2;
            if (plane_a[y * c + x]) packed_mask[bit_pos >> 3][bit_pos & 7] = 1'b1;
         end
      end
   endtask

   task automatic send_item(input kind_type kind, input logic [11:0] faddr,
                            input logic [7:0] fbyte, input logic [10:0] raddr);
      int gap;
      answer_type ans;
      logic rej;
      gap = gap_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.kind            <= kind;
      req_ch.feature_address <= faddr;
      req_ch.feature_byte    <= fbyte;
      req_ch.read_address    <= raddr;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      ans.status      = 1'b0;
      ans.packed_byte = 8'h00;
      case (kind)
         KIND_LOAD: begin
            feat_active[faddr]  = fbyte != 0;
            feat_written[faddr] = 1'b1;
            loads_sent++;
         end
         KIND_BUILD: begin
            predict_mask_build(rej);
            ans.status = rej;
            if (rej) builds_rejected++;
            else builds_ok++;
         end
         KIND_READ: begin
            ans.packed_byte = packed_mask[raddr];
            reads_sent++;
         end
         default: ;
      endcase
      pending_answers.push_back(ans);
   endtask

   task automatic hold_request();
      req_ch.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      hold_request();
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      case (idx)
         REG_ROW_COUNT:       rows_set       = value[7:0];
         REG_COLUMN_COUNT:    cols_set       = value[7:0];
         REG_FEATURE_COUNT:   feat_count_set = value[12:0];
         REG_PACKED_CAPACITY: capacity_set   = value[11:0];
         default: ;
      endcase
   endtask

   task automatic set_image(input int r, input int c, input int fc, input int cap);
      wait_drained();
      csr_write(REG_ROW_COUNT, r);
      csr_write(REG_COLUMN_COUNT, c);
      csr_write(REG_FEATURE_COUNT, fc);
      csr_write(REG_PACKED_CAPACITY, cap);
   endtask

   // write every feature entry a build can read that is still unwritten
   task automatic fill_features(input int density);
      int fi;
      for (int y = 0; y < rows_set && y < 128; y += 2) begin
         for (int x = 2; x + 2 < cols_set && x < 128; x++) begin
            fi = (y / 2) * STRIDE + x / 2;
            if (fi < feat_count_set && fi < FEAT_DEPTH && !feat_written[fi])
               send_item(KIND_LOAD, fi[11:0],
                         ($urandom_range(0, 99) < density) ?
                            8'($urandom_range(1, 255)) : 8'd0,
                         11'd0);
         end
      end
   endtask

   task automatic read_back(input int count, input int span);
      for (int i = 0; i < count; i++)
         send_item(KIND_READ, 12'($urandom), 8'($urandom),
                   11'($urandom_range(0, span - 1)));
   endtask

   function automatic int top_feature(input int r, input int c);
      return ((r - 1) / 2) * STRIDE + (c - 3) / 2;
   endfunction

   function automatic int need_bytes(input int r, input int c);
      return (r * (c - 4) + 7) / 8;
   endfunction

   task automatic test_smallest_image();
      set_image(2, 5, top_feature(2, 5) + 1, need_bytes(2, 5));
      send_item(KIND_READ, 12'hFFF, 8'hFF, 11'd0);
      send_item(KIND_NONE, 12'hFFF, 8'hFF, 11'h7FF);
      send_item(KIND_LOAD, 12'd1, 8'h80, 11'd0);
      send_item(KIND_LOAD, 12'd2, 8'h01, 11'd0);
      send_item(KIND_LOAD, 12'hFFF, 8'hFF, 11'd0);
      send_item(KIND_LOAD, 12'd0, 8'h00, 11'd0);
      send_item(KIND_BUILD, 12'd0, 8'd0, 11'd0);
      read_back(2, 2);
      send_item(KIND_READ, 12'd0, 8'd0, 11'h7FF);
   endtask

   task automatic test_rejected_settings();
      set_image(1, 10, 200, 100);
      send_item(KIND_BUILD, 12'd0, 8'd0, 11'd0);
      set_image(0, 10, 200, 100);
      send_item(KIND_BUILD, 12'd0, 8'd0, 11'd0);
      set_image(6, 4, 200, 100);
      send_item(KIND_BUILD, 12'd0, 8'd0, 11'd0);
      set_image(6, 10, 0, 100);
      send_item(KIND_BUILD, 12'd0, 8'd0, 11'd0);
      set_image(6, 10, top_feature(6, 10) - 1, 100);
      send_item(KIND_BUILD, 12'd0, 8'd0, 11'd0);
      set_image(6, 10, 200, need_bytes(6, 10) - 1);
      send_item(KIND_BUILD, 12'd0, 8'd0, 11'd0);
      set_image(255, 10, 8191, 4095);
      send_item(KIND_BUILD, 12'd0, 8'd0, 11'd0);
      set_image(6, 255, 8191, 0);
      send_item(KIND_BUILD, 12'd0, 8'd0, 11'd0);
      read_back(3, 4);
   endtask

   // last feature index just outside the count, and capacity past the store
   task automatic test_edge_counts();
      set_image(7, 12, top_feature(7, 12), 4095);
      fill_features(70);
      send_item(KIND_BUILD, 12'd0, 8'd0, 11'd0);
      read_back(6, 16);
      send_item(KIND_READ, 12'd0, 8'd0, 11'h7FF);
   endtask

   // tallest and widest images the block takes
   task automatic test_largest_image();
      set_image(128, 5, top_feature(128, 5) + 1, need_bytes(128, 5));
      fill_features(55);
      send_item(KIND_BUILD, 12'd0, 8'd0, 11'd0);
      read_back(12, need_bytes(128, 5));
      set_image(2, 128, top_feature(2, 128) + 1, need_bytes(2, 128));
      fill_features(55);
      send_item(KIND_BUILD, 12'd0, 8'd0, 11'd0);
      read_back(12, need_bytes(2, 128));
   endtask

   task automatic test_random_phases();
      int r, c, fc, cap, sent_start, n;
      sent_start = loads_sent + reads_sent + builds_ok + builds_rejected;
      while (loads_sent + reads_sent + builds_ok + builds_rejected - sent_start < 240) begin
         quiet = $urandom_range(0, 3) == 0;
         r = $urandom_range(2, 12);
         c = $urandom_range(5, 20);
         fc  = top_feature(r, c) + $urandom_range(0, 3);
         cap = need_bytes(r, c) + $urandom_range(0, 20);
         case ($urandom_range(0, 9))
            0: fc = $urandom_range(0, top_feature(r, c));
            1: cap = $urandom_range(0, 4095);
            2: r = $urandom_range(0, 255);
            default: ;
         endcase
         set_image(r, c, fc, cap);
         n = $urandom_range(0, 8);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 5))
               0: send_item(KIND_NONE, 12'($urandom), 8'($urandom), 11'($urandom));
               1: send_item(KIND_READ, 12'($urandom), 8'($urandom),
                            11'($urandom_range(0, PACK_DEPTH - 1)));
               default: send_item(KIND_LOAD, 12'($urandom_range(0, fc + 4)),
                                  8'($urandom), 11'($urandom));
            endcase
         end
         fill_features($urandom_range(20, 90));
         send_item(KIND_BUILD, 12'($urandom), 8'($urandom), 11'($urandom));
         read_back($urandom_range(4, 12), need_bytes(r < 2 ? 2 : r, c) + 3);
      end
      quiet = 1'b0;
   endtask

   // response side: stall, check, watchdog
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready   <= 1'b0;
         rsp_stall_left <= 0;
      end else if (rsp_stall_left > 0) begin
         rsp_ch.ready   <= 1'b0;
         rsp_stall_left <= rsp_stall_left - 1;
      end else if (quiet || $urandom_range(0, 99) < 70) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready   <= 1'b0;
         rsp_stall_left <= gap_len();
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response item status=%0d byte=%02h",
                        rsp_ch.status, rsp_ch.packed_byte);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_ch.status !== want.status || rsp_ch.packed_byte !== want.packed_byte) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: status exp %0d got %0d, byte exp %02h got %02h",
                           want.status, rsp_ch.status, want.packed_byte, rsp_ch.packed_byte);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         watch_count <= 0;
      end else if (watch_count >= WATCH_LIMIT) begin
         $display("binary_mask_upsample_morphology_test: FAIL");
         $finish;
      end else begin
         watch_count <= watch_count + 1;
      end
   end

   initial begin
      reset   = 1'b1;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      req_ch.valid           = 1'b0;
      req_ch.kind            = KIND_NONE;
      req_ch.feature_address = '0;
      req_ch.feature_byte    = '0;
      req_ch.read_address    = '0;
      rsp_ch.ready           = 1'b0;
      mismatches  = 0;
      watch_count = 0;
      quiet       = 1'b0;
      rows_set       = RST_ROW_COUNT;
      cols_set       = RST_COLUMN_COUNT;
      feat_count_set = RST_FEATURE_COUNT;
      capacity_set   = RST_PACKED_CAPACITY;
      for (int i = 0; i < PACK_DEPTH; i++) packed_mask[i] = 8'h00;
      for (int i = 0; i < FEAT_DEPTH; i++) begin
         feat_active[i]  = 1'b0;
         feat_written[i] = 1'b0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_smallest_image();
      test_rejected_settings();
      test_edge_counts();
      test_random_phases();
      test_largest_image();

      hold_request();
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d loads, %0d reads, %0d accepted and %0d rejected builds",
               loads_sent, reads_sent, builds_ok, builds_rejected);
      if (mismatches == 0) begin
         $display("binary_mask_upsample_morphology_test: PASS");
      end else begin
         $display("%0d mismatching response items", mismatches);
         $display("binary_mask_upsample_morphology_test: FAIL");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/bmum_pkg.sv
rtl/core/bmum_req_if.sv
rtl/core/bmum_rsp_if.sv
rtl/core/bmum_source.sv
rtl/core/bmum_cell.sv
rtl/core/bmum_packer.sv
rtl/core/binary_mask_upsample_morphology.sv
dv/binary_mask_upsample_morphology_test.sv
